/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define FRT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define FRT_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
    else $error("forbidden condition seen");
`else
`define FRT_ASSERT(lbl, clk_s, rst_s, prop)
`define FRT_ASSERT_NEVER(lbl, clk_s, rst_s, expr)
`endif

`endif

/* hdl/frt_pkg.sv */
// ---------------------------------------------------------------------------
// frt_pkg
// Shared constants, outcome codes and compare status for the tracker.
// ---------------------------------------------------------------------------
package frt_pkg;

  localparam int FRT_MAX_SETS      = 8;
  localparam int FRT_MAX_FRAGMENTS = 64;
  localparam int FRT_NONCE_BITS    = 32;

  localparam int HOST_W  = 32;
  localparam int PORT_W  = 16;
  localparam int NONCE_W = 32;
  localparam int TOTAL_W = 7;
  localparam int INDEX_W = 6;
  localparam int SLOT_W  = 3;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] CFG_SETS_RESET = 4'd8;

  typedef enum logic [1:0] {
    OC_NEW    = 2'd0,
    OC_ADDED  = 2'd1,
    OC_DUP    = 2'd2,
    OC_REJECT = 2'd3
  } outcome_t;

  // status from the shared entry compare unit
  typedef struct packed {
    logic match;
    logic dup;
    logic complete;
  } cmp_res_t;

endpackage

/* hdl/frt_table.sv */
// ---------------------------------------------------------------------------
// frt_table
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module frt_table
  import frt_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = FRT_MAX_SETS,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hdl/frt_cmp.sv */
// ---------------------------------------------------------------------------
// frt_cmp
// Shared compare unit: key match, seen-bit test and bitmap/count update.
// ---------------------------------------------------------------------------
module frt_cmp
  import frt_pkg::*;
#(
  parameter int NB  = 32,
  parameter int MF  = FRT_MAX_FRAGMENTS,
  parameter int AW  = 7,
  parameter int FIW = 6
) (
  input  logic               ent_valid,
  input  logic [HOST_W-1:0]  ent_host,
  input  logic [PORT_W-1:0]  ent_port,
  input  logic [NB-1:0]      ent_nonce,
  input  logic [TOTAL_W-1:0] ent_total,
  input  logic [MF-1:0]      ent_seen,
  input  logic [AW-1:0]      ent_arrived,
  input  logic [HOST_W-1:0]  key_host,
  input  logic [PORT_W-1:0]  key_port,
  input  logic [NB-1:0]      key_nonce,
  input  logic [TOTAL_W-1:0] key_total,
  input  logic [FIW-1:0]     key_index,
  output cmp_res_t           res,
  output logic [MF-1:0]      seen_nxt,
  output logic [AW-1:0]      arrived_nxt
);

  logic [MF-1:0] bit_sel;
  logic          seen_hit;

  assign bit_sel  = MF'(1) << key_index;
  assign seen_hit = |(ent_seen & bit_sel);

  assign seen_nxt    = ent_seen | bit_sel;
  assign arrived_nxt = ent_arrived + AW'(1);

  always_comb begin
    res.match = ent_valid && (ent_host == key_host) && (ent_port == key_port) &&
                (ent_nonce == key_nonce) && (ent_total == key_total);
    res.dup   = seen_hit;
    // a duplicate leaves the count as is
    res.complete = seen_hit ? (TOTAL_W'(ent_arrived) == ent_total)
                            : (TOTAL_W'(arrived_nxt) == ent_total);
  end

endmodule

/* hdl/fragment_reassembly_tracker_unit.sv */
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker_unit
// Tracks partial fragmented messages in a FIFO-evicted table of entries.
// ---------------------------------------------------------------------------
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid/in_ready + fragment header    | sink
//  out     | out_valid/out_ready + slot/outcome/... | source
//  cfg     | cfg_valid/cfg_ready + cfg_sets_in_use  | sink
//
//  A fragment that matches the j-th newest entry is accepted, the j newest
//  entries are read with the shared compare one read behind, and the result
//  is handed over. A fragment that opens an entry is accepted, all live
//  entries are read, the compare is drained and the search closed, oldest
//  entries are evicted one at a time as needed, the new entry is opened and
//  the result handed over. The single-read-port store and the one shared
//  compare unit make the search go one entry at a time. Bad headers skip
//  the search. in_ready is low while a fragment is in work. A finished
//  result waits in the output register; a new fragment may be taken while
//  it waits, and its own result stalls until the register is free. Reset
//  clears all entry valid bits at once; no clearing pass is needed.
//
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fragment_reassembly_tracker_unit
  import frt_pkg::*;
#(
  parameter int MAX_SETS      = FRT_MAX_SETS,
  parameter int MAX_FRAGMENTS = FRT_MAX_FRAGMENTS,
  parameter int NONCE_BITS    = FRT_NONCE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // fragment header transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [HOST_W-1:0]  in_sender_host,
  input  logic [PORT_W-1:0]  in_sender_port,
  input  logic [NONCE_W-1:0] in_message_nonce,
  input  logic [TOTAL_W-1:0] in_fragment_total,
  input  logic [INDEX_W-1:0] in_fragment_index,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [1:0]         out_outcome,
  output logic               out_evicted,
  output logic               out_message_complete,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_sets_in_use
);

  // only the low NONCE_BITS bits of the nonce, at most the port width, are ever compared
  localparam int NB   = (NONCE_BITS < NONCE_W) ? NONCE_BITS : NONCE_W;
  localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int OCW  = $clog2(MAX_SETS + 1);
  localparam int AW   = $clog2(MAX_FRAGMENTS + 1);
  localparam int FIW  = $clog2(MAX_FRAGMENTS);
  localparam int WORD = HOST_W + PORT_W + NB + TOTAL_W + MAX_FRAGMENTS + AW;

  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SETS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EVICT,
    ST_RESULT
  } state_t;

  state_t                state_r;

  // table bookkeeping
  logic [MAX_SETS-1:0]   valid_r;
  logic [SW-1:0]         oldest_r;
  logic [SW-1:0]         tail_r;      // slot the next new entry goes to
  logic [OCW-1:0]        occ_r;
  logic [CFG_W-1:0]      sets_r;

  // search sequencer
  logic [SW-1:0]         rd_ptr_r;
  logic [OCW-1:0]        issue_left_r;
  logic [SW-1:0]         cmp_slot_r;
  logic                  cmp_vld_r;

  // captured fragment key
  logic [HOST_W-1:0]     key_host_r;
  logic [PORT_W-1:0]     key_port_r;
  logic [NB-1:0]         key_nonce_r;
  logic [TOTAL_W-1:0]    key_total_r;
  logic [FIW-1:0]        key_index_r;

  // pending result
  logic [SW-1:0]         res_slot_r;
  outcome_t              res_outcome_r;
  logic                  res_evicted_r;
  logic                  res_complete_r;

  // output register
  logic                  out_valid_r;
  logic [SW-1:0]         out_slot_r;
  outcome_t              out_outcome_r;
  logic                  out_evicted_r;
  logic                  out_complete_r;

  // entry store ports
  logic                  tbl_we;
  logic [SW-1:0]         tbl_waddr;
  logic [WORD-1:0]       tbl_wdata;
  logic                  tbl_re;
  logic [WORD-1:0]       tbl_rdata;

  // unpacked read word
  logic [HOST_W-1:0]        ent_host;
  logic [PORT_W-1:0]        ent_port;
  logic [NB-1:0]            ent_nonce;
  logic [TOTAL_W-1:0]       ent_total;
  logic [MAX_FRAGMENTS-1:0] ent_seen;
  logic [AW-1:0]            ent_arrived;

  cmp_res_t                 cmp_res;
  logic [MAX_FRAGMENTS-1:0] seen_nxt;
  logic [AW-1:0]            arrived_nxt;

  logic                  in_acc;
  logic                  bad_hdr;
  logic                  hit;
  logic                  must_evict;
  logic [OCW-1:0]        cap;
  logic                  out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_slot             = SLOT_W'(out_slot_r);
  assign out_outcome          = out_outcome_r;
  assign out_evicted          = out_evicted_r;
  assign out_message_complete = out_complete_r;

  // zero count, count beyond the table's bitmap, or index past the count
  assign bad_hdr = (in_fragment_total == '0) ||
                   (int'(in_fragment_total) > MAX_FRAGMENTS) ||
                   ({1'b0, in_fragment_index} >= in_fragment_total);

  // register value 0 acts as 1, values above the table depth are clipped
  always_comb begin
    if (sets_r == '0) begin
      cap = OCW'(1);
    end else if (int'(sets_r) > MAX_SETS) begin
      cap = OCW'(MAX_SETS);
    end else begin
      cap = OCW'(sets_r);
    end
  end

  assign must_evict = (occ_r >= cap) && (occ_r != '0);
  assign hit        = cmp_vld_r && cmp_res.match;

  assign {ent_host, ent_port, ent_nonce, ent_total, ent_seen, ent_arrived} = tbl_rdata;

  // one read per search cycle while reads remain, walking from newest toward oldest
  assign tbl_re = (state_r == ST_SEARCH) && (issue_left_r != '0);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cmp_slot_r;
    tbl_wdata = {key_host_r, key_port_r, key_nonce_r, key_total_r, seen_nxt, arrived_nxt};
    if (state_r == ST_SEARCH && hit && !cmp_res.dup) begin
      tbl_we = 1'b1;
    end else if (state_r == ST_EVICT && !must_evict) begin
      tbl_we    = 1'b1;
      tbl_waddr = tail_r;
      tbl_wdata = {key_host_r, key_port_r, key_nonce_r, key_total_r,
                   MAX_FRAGMENTS'(1) << key_index_r, AW'(1)};
    end
  end

  frt_table #(
    .WIDTH (WORD),
    .DEPTH (MAX_SETS),
    .AW    (SW)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .re      (tbl_re),
    .raddr   (rd_ptr_r),
    .rdata_r (tbl_rdata)
  );

  frt_cmp #(
    .NB  (NB),
    .MF  (MAX_FRAGMENTS),
    .AW  (AW),
    .FIW (FIW)
  ) u_cmp (
    .ent_valid   (valid_r[cmp_slot_r]),
    .ent_host    (ent_host),
    .ent_port    (ent_port),
    .ent_nonce   (ent_nonce),
    .ent_total   (ent_total),
    .ent_seen    (ent_seen),
    .ent_arrived (ent_arrived),
    .key_host    (key_host_r),
    .key_port    (key_port_r),
    .key_nonce   (key_nonce_r),
    .key_total   (key_total_r),
    .key_index   (key_index_r),
    .res         (cmp_res),
    .seen_nxt    (seen_nxt),
    .arrived_nxt (arrived_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      oldest_r     <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      sets_r       <= CFG_SETS_RESET;
      cmp_vld_r    <= 1'b0;
      issue_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sets_r <= cfg_sets_in_use;
      end
      // in ST_RESULT the hand-over below refills the register instead
      if (out_valid_r && out_ready && state_r != ST_RESULT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            key_host_r    <= in_sender_host;
            key_port_r    <= in_sender_port;
            key_nonce_r   <= in_message_nonce[NB-1:0];
            key_total_r   <= in_fragment_total;
            key_index_r   <= in_fragment_index[FIW-1:0];
            res_evicted_r <= 1'b0;
            cmp_vld_r     <= 1'b0;
            issue_left_r  <= occ_r;
            rd_ptr_r      <= (tail_r == '0) ? LAST_SLOT : tail_r - SW'(1);
            if (bad_hdr) begin
              res_slot_r     <= '0;
              res_outcome_r  <= OC_REJECT;
              res_complete_r <= 1'b0;
              state_r        <= ST_RESULT;
            end else begin
              state_r <= ST_SEARCH;
            end
          end
        end

        ST_SEARCH: begin
          // pipelined: compare last read while issuing the next
          if (tbl_re) begin
            cmp_slot_r   <= rd_ptr_r;
            rd_ptr_r     <= (rd_ptr_r == '0) ? LAST_SLOT : rd_ptr_r - SW'(1);
            issue_left_r <= issue_left_r - OCW'(1);
          end
          cmp_vld_r <= tbl_re;
          if (hit) begin
            res_slot_r     <= cmp_slot_r;
            res_outcome_r  <= cmp_res.dup ? OC_DUP : OC_ADDED;
            res_complete_r <= cmp_res.complete;
            state_r        <= ST_RESULT;
          end else if (!cmp_vld_r && issue_left_r == '0) begin
            state_r <= ST_EVICT;
          end
        end

        ST_EVICT: begin
          if (must_evict) begin
            // drop the oldest entry, one per cycle
            valid_r[oldest_r] <= 1'b0;
            oldest_r          <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + SW'(1);
            occ_r             <= occ_r - OCW'(1);
            res_evicted_r     <= 1'b1;
          end else begin
            valid_r[tail_r] <= 1'b1;
            tail_r          <= (tail_r == LAST_SLOT) ? '0 : tail_r + SW'(1);
            occ_r           <= occ_r + OCW'(1);
            res_slot_r      <= tail_r;
            res_outcome_r   <= OC_NEW;
            res_complete_r  <= (key_total_r == TOTAL_W'(1));
            state_r         <= ST_RESULT;
          end
        end

        ST_RESULT: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_slot_r     <= res_slot_r;
            out_outcome_r  <= res_outcome_r;
            out_evicted_r  <= res_evicted_r;
            out_complete_r <= res_complete_r;
            state_r        <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // valid bits and occupancy must track each other
  `FRT_ASSERT(a_occ_count, clk, rst_n, $countones(valid_r) == int'(occ_r))
  `FRT_ASSERT_NEVER(a_occ_max, clk, rst_n, int'(occ_r) > MAX_SETS)
  // every slot the search compares lies inside the live ring
  `FRT_ASSERT(a_cmp_live, clk, rst_n,
              (state_r == ST_SEARCH && cmp_vld_r) |-> valid_r[cmp_slot_r])
  // a rejected header reports no slot, eviction or completion
  `FRT_ASSERT(a_reject_clean, clk, rst_n,
              (out_valid_r && out_outcome_r == OC_REJECT) |->
                (out_slot_r == '0 && !out_evicted_r && !out_complete_r))

endmodule
